// ----- hw/rtl/c3f_pkg.sv -----
// Shared types and constants of the 3x3 convolution filter.
`timescale 1ns / 1ps
package c3f_pkg;

   localparam int COEF_FRAC_BITS = 12;
   localparam int MAX_HEIGHT     = 2048;
   localparam int ROW_BITS       = 11;
   localparam int OROW_BITS      = 12;
   localparam int HEIGHT_BITS    = 12;
   localparam int NUM_CHANNELS   = 4;
   localparam int PIXEL_BITS     = 32;
   localparam int PROD_BITS      = 25;
   localparam int SUM_BITS       = 29;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MID    = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4,
      CSR_CHANNEL_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic produce;
      logic interior;
      logic frame_end;
   } flags_type;

   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [SUM_BITS-1:0]  sum_type;

endpackage

// ----- hw/rtl/conv3x3_image_filter.sv -----
// Streaming 3x3 convolution filter over raster-order pixels of up to four channels.
//
// Channels: req_* carries one transaction per pixel (command pixel) or one drain
// request (command drain); rsp_* returns filtered pixels in raster order, each one
// row and one column behind its input. csr_* writes the kernel rows, image size and
// channel count; it is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. After the last pixel of a frame,
// width+1 drain transactions release the remaining results; rsp_frame_end marks the
// last pixel of the frame. Throughput: one transaction per cycle while the output is
// not stalled. The line stores sit in one 64-bit RAM read at the pixel's column on the
// accepting edge and written back when that item advances out of the first stage;
// a read that hits the entry written in that cycle takes the forwarded value.
// A releasing transaction passes the window update, multiply, sum and output register
// before rsp_valid rises. Reset: counters, window and output valid clear; kernel goes
// to a lone 4096 (1.0) tap, middle row left, 512x512 frame, 3 channels. The line store
// RAM is not cleared. Stall: while rsp_valid is high and rsp_ready low the whole
// pipeline holds and req_ready is low.
`timescale 1ns / 1ps
module conv3x3_image_filter #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  c3f_pkg::cmd_type        req_command,
   input  logic [7:0]              req_chan0_in,
   input  logic [7:0]              req_chan1_in,
   input  logic [7:0]              req_chan2_in,
   input  logic [7:0]              req_chan3_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_chan0_out,
   output logic [7:0]              rsp_chan1_out,
   output logic [7:0]              rsp_chan2_out,
   output logic [7:0]              rsp_chan3_out,
   output logic                    rsp_frame_end,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [47:0]             csr_wdata
);
   import c3f_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;

   logic [47:0] kernel_ff [3];
   logic [11:0] image_width_ff, image_height_ff;
   logic [2:0]  channel_count_ff;

   logic [WW-1:0]          w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic [2:0]             n_eff;

   logic [CW-1:0]        col_ff, col_in, col_cur;
   logic [ROW_BITS-1:0]  row_ff, row_in, row_cur;
   logic [CW-1:0]        ocol_ff, ocol_in, ocol_cur;
   logic [OROW_BITS-1:0] orow_ff, orow_in, orow_cur;
   logic                 done_ff, done_in;

   logic advance, accept, is_pixel;
   flags_type s0_flags;
   logic s0_sel_lower;
   logic [CW-1:0] rd_addr;

   logic          s1_valid_ff, s1_pixel_ff, s1_sel_lower_ff, s1_fwd_ff;
   flags_type     s1_flags_ff;
   logic [CW-1:0] s1_addr_ff;
   logic [31:0]   s1_px_ff;
   logic [63:0]   s1_fwd_data_ff, ram_rd_data, ram_q, ram_wr_data;
   logic          ram_wr_en;

   logic [31:0] win_ff [9];
   logic [31:0] s1_center;

   flags_type   s2_flags_ff, s3_flags_ff, s4_flags_ff;
   logic [31:0] s2_center_ff, s3_center_ff, s4_center_ff;
   prod_type    prod_in [NUM_CHANNELS][9];
   prod_type    prod_ff [NUM_CHANNELS][9];
   sum_type     sum_in [NUM_CHANNELS];
   sum_type     sum_ff [NUM_CHANNELS];

   logic       rsp_valid_ff, rsp_frame_end_ff;
   logic [7:0] rsp_chan_ff [NUM_CHANNELS];
   logic [7:0] rsp_chan_in [NUM_CHANNELS];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;
   assign is_pixel  = (req_command == CMD_PIXEL);

   always_comb begin
      if (image_width_ff < 12'd3) begin
         w_eff = WW'(3);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      if (image_height_ff < 12'd3) begin
         h_eff = HEIGHT_BITS'(3);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
      if (channel_count_ff == 3'd0) begin
         n_eff = 3'd1;
      end else if (channel_count_ff > 3'(NUM_CHANNELS)) begin
         n_eff = 3'(NUM_CHANNELS);
      end else begin
         n_eff = channel_count_ff;
      end
   end

   // Front end: frame counters and what the item will produce.
   always_comb begin
      col_cur  = col_ff;
      row_cur  = row_ff;
      ocol_cur = ocol_ff;
      orow_cur = orow_ff;
      done_in  = done_ff;
      if (is_pixel && done_ff) begin
         col_cur  = '0;
         row_cur  = '0;
         ocol_cur = '0;
         orow_cur = '0;
         done_in  = 1'b0;
      end
      s0_flags.frame_end = (orow_cur == h_eff - 1'b1) && ({1'b0, ocol_cur} == w_eff - 1'b1);
      s0_sel_lower       = (orow_cur == h_eff - 1'b1);
      if (is_pixel) begin
         s0_flags.produce  = (row_cur >= ROW_BITS'(2)) || (row_cur == ROW_BITS'(1) && col_cur != '0);
         s0_flags.interior = orow_cur != '0 && orow_cur < h_eff - 1'b1 && ocol_cur != '0
                             && {1'b0, ocol_cur} < w_eff - 1'b1 && col_cur >= CW'(2);
         rd_addr = col_cur;
      end else begin
         s0_flags.produce  = done_ff && (orow_cur < h_eff);
         s0_flags.interior = 1'b0;
         rd_addr = ocol_cur;
      end
      ocol_in = ocol_cur;
      orow_in = orow_cur;
      if (s0_flags.produce) begin
         if ({1'b0, ocol_cur} == w_eff - 1'b1) begin
            ocol_in = '0;
            orow_in = orow_cur + 1'b1;
         end else begin
            ocol_in = ocol_cur + 1'b1;
         end
      end
      col_in = col_cur;
      row_in = row_cur;
      if (is_pixel) begin
         if ({1'b0, col_cur} == w_eff - 1'b1) begin
            col_in = '0;
            if ({1'b0, row_cur} == h_eff - 1'b1) begin
               row_in  = '0;
               done_in = 1'b1;
            end else begin
               row_in = row_cur + 1'b1;
            end
         end else begin
            col_in = col_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0]     <= 48'd0;
         kernel_ff[1]     <= 48'd4096;
         kernel_ff[2]     <= 48'd0;
         image_width_ff   <= 12'd512;
         image_height_ff  <= 12'd512;
         channel_count_ff <= 3'd3;
         col_ff  <= '0;
         row_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            ocol_ff <= ocol_in;
            orow_ff <= orow_in;
            done_ff <= done_in;
         end
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata;
               CSR_KERNEL_MID:    kernel_ff[1] <= csr_wdata;
               CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata;
               CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT: begin
                  if (csr_index_type'(csr_index) == CSR_IMAGE_WIDTH) begin
                     image_width_ff <= csr_wdata[11:0];
                  end else begin
                     image_height_ff <= csr_wdata[11:0];
                  end
                  col_ff  <= '0;
                  row_ff  <= '0;
                  ocol_ff <= '0;
                  orow_ff <= '0;
                  done_ff <= 1'b0;
               end
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[2:0];
               default: ;
            endcase
         end
      end
   end

   // Line stores: upper row in [31:0], lower row in [63:32].
   c3f_ram #(.WIDTH(64), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_q       = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign ram_wr_en   = advance && s1_valid_ff && s1_pixel_ff;
   assign ram_wr_data = {s1_px_ff, ram_q[63:32]};
   assign s1_center   = s1_pixel_ff ? win_ff[5] : (s1_sel_lower_ff ? ram_q[63:32] : ram_q[31:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_pixel_ff     <= is_pixel;
         s1_flags_ff     <= s0_flags;
         s1_sel_lower_ff <= s0_sel_lower;
         s1_addr_ff      <= rd_addr;
         s1_px_ff        <= {req_chan3_in, req_chan2_in, req_chan1_in, req_chan0_in};
         s1_fwd_ff       <= ram_wr_en && (s1_addr_ff == rd_addr);
         s1_fwd_data_ff  <= ram_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance && s1_valid_ff && s1_pixel_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= ram_q[31:0];
         win_ff[5] <= ram_q[63:32];
         win_ff[8] <= s1_px_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         for (int i = 0; i < 9; i++) begin
            prod_in[ch][i] = PROD_BITS'($signed({1'b0, win_ff[i][8*ch +: 8]})
                             * $signed(kernel_ff[i/3][16*(i%3) +: 16]));
         end
      end
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         sum_in[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            sum_in[ch] = sum_in[ch] + SUM_BITS'(prod_ff[ch][i]);
         end
      end
   end

   always_comb begin
      logic [SUM_BITS-1:0] mag;
      logic [SUM_BITS-1:0] scaled;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         mag    = sum_ff[ch][SUM_BITS-1] ? SUM_BITS'(-sum_ff[ch]) : SUM_BITS'(sum_ff[ch]);
         scaled = mag >> COEF_FRAC_BITS;
         if (3'(ch) >= n_eff) begin
            rsp_chan_in[ch] = 8'd0;
         end else if (!s4_flags_ff.interior) begin
            rsp_chan_in[ch] = s4_center_ff[8*ch +: 8];
         end else if (scaled > SUM_BITS'(255)) begin
            rsp_chan_in[ch] = 8'd255;
         end else begin
            rsp_chan_in[ch] = scaled[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_flags_ff.produce <= 1'b0;
         s3_flags_ff.produce <= 1'b0;
         s4_flags_ff.produce <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else if (advance) begin
         s2_flags_ff.produce <= s1_valid_ff && s1_flags_ff.produce;
         s3_flags_ff.produce <= s2_flags_ff.produce;
         s4_flags_ff.produce <= s3_flags_ff.produce;
         rsp_valid_ff        <= s4_flags_ff.produce;
      end
      if (advance) begin
         s2_flags_ff.interior  <= s1_flags_ff.interior;
         s2_flags_ff.frame_end <= s1_flags_ff.frame_end;
         s2_center_ff          <= s1_center;
         s3_flags_ff.interior  <= s2_flags_ff.interior;
         s3_flags_ff.frame_end <= s2_flags_ff.frame_end;
         s3_center_ff          <= s2_center_ff;
         prod_ff               <= prod_in;
         s4_flags_ff.interior  <= s3_flags_ff.interior;
         s4_flags_ff.frame_end <= s3_flags_ff.frame_end;
         s4_center_ff          <= s3_center_ff;
         sum_ff                <= sum_in;
         rsp_chan_ff           <= rsp_chan_in;
         rsp_frame_end_ff      <= s4_flags_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_chan0_out = rsp_chan_ff[0];
   assign rsp_chan1_out = rsp_chan_ff[1];
   assign rsp_chan2_out = rsp_chan_ff[2];
   assign rsp_chan3_out = rsp_chan_ff[3];
   assign rsp_frame_end = rsp_frame_end_ff;
endmodule

// ----- hw/rtl/c3f_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module c3f_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- hw/rtl/c3f_checker.sv -----
// Port-level checks of the convolution filter, bound to the top level.
`timescale 1ns / 1ps
module c3f_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_chan0_out,
   input logic       rsp_frame_end,
   input logic       csr_ready
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chan0_out)
      && $stable(rsp_frame_end))
      else $error("stalled response changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr port not ready");
endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_chan0_out (rsp_chan0_out),
   .rsp_frame_end (rsp_frame_end),
   .csr_ready     (csr_ready)
);
